>>> rtl/core/lfu_cache_replacement_defines.svh
// Assertion helpers for the replacement directory.
`ifndef LFU_CACHE_REPLACEMENT_DEFINES_SVH
`define LFU_CACHE_REPLACEMENT_DEFINES_SVH

// Check a same-cycle implication.
`define LFU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check a next-cycle implication.
`define LFU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/lfu_pkg.sv
`default_nettype none
package lfu_pkg;
  localparam int CNT_W = 32;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef struct packed {
    logic cnt_en;
    logic fill;
  } lfu_wr_t;
endpackage
`default_nettype wire

>>> rtl/core/lfu_slot_store.sv
`default_nettype none
module lfu_slot_store #(
  parameter int NUM_SLOTS = 64,
  parameter int KEY_BITS  = 20
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              rd_en,
  input  wire [$clog2(NUM_SLOTS)-1:0]      rd_idx,
  output logic                             rd_valid,
  output logic [KEY_BITS-1:0]              rd_key,
  output logic [lfu_pkg::CNT_W-1:0]        rd_cnt,
  output logic [lfu_pkg::CNT_W-1:0]        rd_stamp,
  input  wire lfu_pkg::lfu_wr_t            wr,
  input  wire [$clog2(NUM_SLOTS)-1:0]      wr_idx,
  input  wire [KEY_BITS-1:0]               wr_key,
  input  wire [lfu_pkg::CNT_W-1:0]         wr_cnt,
  input  wire [lfu_pkg::CNT_W-1:0]         wr_stamp
);
  logic [KEY_BITS-1:0]       key_mem   [NUM_SLOTS];
  logic [lfu_pkg::CNT_W-1:0] cnt_mem   [NUM_SLOTS];
  logic [lfu_pkg::CNT_W-1:0] stamp_mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]      valid;

  always_ff @(posedge clk) begin
    if (wr.fill) begin
      key_mem[wr_idx]   <= wr_key;
      stamp_mem[wr_idx] <= wr_stamp;
    end
    if (wr.cnt_en) begin
      cnt_mem[wr_idx] <= wr_cnt;
    end
    if (rd_en) begin
      rd_key   <= key_mem[rd_idx];
      rd_cnt   <= cnt_mem[rd_idx];
      rd_stamp <= stamp_mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr.fill) begin
        valid[wr_idx] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= valid[rd_idx];
      end
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/lfu_cache_replacement.sv
`default_nettype none
// Fully associative LFU cache directory, keys only.
// Request channel: drive request_key and raise start; the request is taken
// at an edge where start is high and busy is low. busy stays high until the
// result is out.
// Result channel: done is high for one cycle with hit, slot_used, evicted,
// evicted_key and hit_total; the receiver cannot stall, so take it then.
// Config channel: cfg_data (slots_in_use) is written when cfg_valid and
// cfg_ready are high; cfg_ready is always high. Write only while idle.
// Scan: the active slots (slots_in_use, at least one and at most NUM_SLOTS)
// are read from the slot memories one entry per cycle through one read port;
// one request in flight, so the next request is taken only once busy is low.
// Reset clears the valid bits, the time and hit counters and restores
// slots_in_use to NUM_SLOTS; no clearing pass is needed.
module lfu_cache_replacement #(
  parameter int NUM_SLOTS = 64,
  parameter int KEY_BITS  = 20
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         start,
  output logic        busy,
  input  wire  [19:0] request_key,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [6:0]  cfg_data,
  output logic        done,
  output logic        hit,
  output logic [5:0]  slot_used,
  output logic        evicted,
  output logic [19:0] evicted_key,
  output logic [31:0] hit_total
);
`include "lfu_cache_replacement_defines.svh"

  localparam int IW = $clog2(NUM_SLOTS);
  localparam int SW = (IW + 1 > 7) ? IW + 1 : 7;
  localparam int CW = lfu_pkg::CNT_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]          state;
  logic [SW-1:0]       siu;
  logic [SW-1:0]       act;
  logic [KEY_BITS-1:0] req_key;
  logic [CW-1:0]       tcount;
  logic [CW-1:0]       hits;
  logic [IW:0]         rd_ptr;
  logic [IW-1:0]       rd_idx_q;
  logic                rd_vld_q;
  logic                issue;

  logic                match_f;
  logic [IW-1:0]       match_idx;
  logic [CW-1:0]       match_cnt;
  logic                empty_f;
  logic [IW-1:0]       empty_idx;
  logic                vic_f;
  logic [IW-1:0]       vic_idx;
  logic [CW-1:0]       vic_cnt;
  logic [CW-1:0]       vic_stamp;
  logic [KEY_BITS-1:0] vic_key;

  logic                rd_valid;
  logic [KEY_BITS-1:0] rd_key;
  logic [CW-1:0]       rd_cnt;
  logic [CW-1:0]       rd_stamp;
  lfu_pkg::lfu_wr_t    wr;
  logic [IW-1:0]       wr_idx;
  logic [CW-1:0]       wr_cnt;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign hit_total = hits;

  always_comb begin
    if (siu == '0) begin
      act = SW'(1);
    end else if (siu > SW'(NUM_SLOTS)) begin
      act = SW'(NUM_SLOTS);
    end else begin
      act = siu;
    end
  end

  assign issue = (state == S_SCAN) && (SW'(rd_ptr) < act);

  always_comb begin
    wr     = '0;
    wr_idx = match_idx;
    wr_cnt = CW'(1);
    if (state == S_FIN) begin
      if (match_f) begin
        wr.cnt_en = 1'b1;
        wr_cnt    = (match_cnt == lfu_pkg::CNT_MAX) ? match_cnt : match_cnt + CW'(1);
      end else begin
        wr.cnt_en = 1'b1;
        wr.fill   = 1'b1;
        wr_idx    = empty_f ? empty_idx : vic_idx;
      end
    end
  end

  lfu_slot_store #(
    .NUM_SLOTS(NUM_SLOTS),
    .KEY_BITS (KEY_BITS)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (issue),
    .rd_idx   (rd_ptr[IW-1:0]),
    .rd_valid (rd_valid),
    .rd_key   (rd_key),
    .rd_cnt   (rd_cnt),
    .rd_stamp (rd_stamp),
    .wr       (wr),
    .wr_idx   (wr_idx),
    .wr_key   (req_key),
    .wr_cnt   (wr_cnt),
    .wr_stamp (tcount)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      siu      <= SW'(NUM_SLOTS);
      tcount   <= '0;
      hits     <= '0;
      rd_vld_q <= 1'b0;
      done     <= 1'b0;
    end else begin
      done     <= 1'b0;
      rd_vld_q <= issue;
      if (cfg_valid && cfg_ready) begin
        siu <= SW'(cfg_data);
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            state  <= S_SCAN;
            tcount <= (tcount == lfu_pkg::CNT_MAX) ? tcount : tcount + CW'(1);
          end
        end
        S_SCAN: begin
          if (!issue && !rd_vld_q) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          state <= S_IDLE;
          done  <= 1'b1;
          if (match_f && hits != lfu_pkg::CNT_MAX) begin
            hits <= hits + CW'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      req_key <= KEY_BITS'(request_key);
      rd_ptr  <= '0;
      match_f <= 1'b0;
      empty_f <= 1'b0;
      vic_f   <= 1'b0;
    end
    if (issue) begin
      rd_ptr   <= rd_ptr + (IW+1)'(1);
      rd_idx_q <= rd_ptr[IW-1:0];
    end
    if (rd_vld_q) begin
      if (rd_valid) begin
        if (!match_f && rd_key == req_key) begin
          match_f   <= 1'b1;
          match_idx <= rd_idx_q;
          match_cnt <= rd_cnt;
        end
        if (!vic_f || rd_cnt < vic_cnt || (rd_cnt == vic_cnt && rd_stamp < vic_stamp)) begin
          vic_f     <= 1'b1;
          vic_idx   <= rd_idx_q;
          vic_cnt   <= rd_cnt;
          vic_stamp <= rd_stamp;
          vic_key   <= rd_key;
        end
      end else if (!empty_f) begin
        empty_f   <= 1'b1;
        empty_idx <= rd_idx_q;
      end
    end
    if (state == S_FIN) begin
      hit         <= match_f;
      slot_used   <= 6'(wr_idx);
      evicted     <= !match_f && !empty_f;
      evicted_key <= (!match_f && !empty_f) ? 20'(vic_key) : 20'd0;
    end
  end

  `LFU_ASSERT_NXT(a_start_busy, start && !busy, busy, "accepted request did not raise busy")
  `LFU_ASSERT_IMP(a_done_idle, done, !busy, "result strobe while still busy")
  `LFU_ASSERT_IMP(a_hit_no_evict, done && hit, !evicted, "hit reported with an eviction")
  `LFU_ASSERT_IMP(a_evkey_zero, done && !evicted, evicted_key == 20'd0, "stale evicted key")
endmodule
`default_nettype wire
